FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the framer checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active-low reset).
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("framer assertion failed");

// Clocked assertion that is also checked while reset is asserted.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("framer assertion failed");

`endif

FILE: sv/hbsf_pkg.sv
// ----------------------------------------------------------------------------
// hbsf_pkg
// Types, constants and the CRC-16/X-25 byte update for the HDLC framer.
// ----------------------------------------------------------------------------
package hbsf_pkg;

	// job queue between front and serializer
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [15:0] CRC_POLY  = 16'h8408;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [2:0]  RUN_LIMIT = 3'd5;

	// one accepted byte with everything the serializer needs
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        open;
		logic [15:0] fcs;
	} job_t;

	// serializer segments
	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_OPEN   = 6'b000010,
		PH_DATA   = 6'b000100,
		PH_FCS_LO = 6'b001000,
		PH_FCS_HI = 6'b010000,
		PH_CLOSE  = 6'b100000
	} phase_t;

	// reflected CRC-16 update over one byte, LSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: sv/hbsf_queue.sv
// ----------------------------------------------------------------------------
// hbsf_queue
// Small register FIFO holding classified jobs between front and serializer.
// ----------------------------------------------------------------------------
module hbsf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hbsf_pkg::job_t wdata,
	output logic          full,
	input  logic          pop,
	output hbsf_pkg::job_t rdata,
	output logic          empty
);
	import hbsf_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// storage, no reset on payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/hbsf_front.sv
// ----------------------------------------------------------------------------
// hbsf_front
// Accepts frame bytes, tracks frame state and the running CRC, and builds
// one job per byte for the serializer.
// ----------------------------------------------------------------------------
module hbsf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     data_byte,
	input  logic           frame_end,
	output hbsf_pkg::job_t job
);
	import hbsf_pkg::*;

	logic [15:0] crc_q;
	logic        in_frame_q;
	logic [15:0] crc_base;
	logic [15:0] crc_nx;

	// a new frame restarts the CRC
	assign crc_base = in_frame_q ? crc_q : CRC_INIT;
	assign crc_nx   = crc_feed(crc_base, data_byte);

	// classify the byte
	always_comb begin
		job.data = data_byte;
		job.last = frame_end;
		job.open = !in_frame_q;
		job.fcs  = ~crc_nx;
	end

	// frame and CRC state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			in_frame_q <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				crc_q      <= CRC_INIT;
				in_frame_q <= 1'b0;
			end else begin
				crc_q      <= crc_nx;
				in_frame_q <= 1'b1;
			end
		end
	end

endmodule

FILE: sv/hbsf_serializer.sv
// ----------------------------------------------------------------------------
// hbsf_serializer
// Walks each job through the segments it needs (flag, data, FCS, flag) at one
// bit per cycle unless pop stalls, inserts stuffed zeros, registers the bit.
// ----------------------------------------------------------------------------
module hbsf_serializer (
	input  logic           clk,
	input  logic           arst_n,
	input  hbsf_pkg::job_t q_data,
	input  logic           q_empty,
	output logic           q_pop,
	output logic           line_bit,
	output logic           run_end,
	output logic           empty,
	input  logic           pop
);
	import hbsf_pkg::*;

	phase_t     phase_q;
	phase_t     phase_nx;
	job_t       job_q;
	logic [2:0] bit_cnt_q;
	logic [2:0] ones_q;
	logic       stuff_q;
	logic       ovalid_q;
	logic       line_bit_q;
	logic       run_end_q;

	logic       slot_free;
	logic       emit;
	logic [7:0] seg_byte;
	logic       is_flag;
	logic       cur_bit;
	logic       out_bit;
	logic [2:0] ones_inc;
	logic       need_stuff;
	logic       seg_end;
	logic       item_done;
	logic       load;

	assign empty    = !ovalid_q;
	assign line_bit = line_bit_q;
	assign run_end  = run_end_q;

	// output slot frees when empty or taken this cycle
	assign slot_free = !ovalid_q || pop;
	assign emit      = slot_free && (phase_q != PH_IDLE);

	// byte of the current segment
	always_comb begin
		case (phase_q)
			PH_OPEN:   seg_byte = FLAG_BYTE;
			PH_CLOSE:  seg_byte = FLAG_BYTE;
			PH_DATA:   seg_byte = job_q.data;
			PH_FCS_LO: seg_byte = job_q.fcs[7:0];
			PH_FCS_HI: seg_byte = job_q.fcs[15:8];
			default:   seg_byte = 8'h00;
		endcase
	end

	assign is_flag    = (phase_q == PH_OPEN) || (phase_q == PH_CLOSE);
	assign cur_bit    = seg_byte[bit_cnt_q];
	assign ones_inc   = cur_bit ? (ones_q + 3'd1) : 3'd0;
	assign need_stuff = !is_flag && !stuff_q && (ones_inc >= RUN_LIMIT);

	// bit selection and segment end; a stuffed zero after bit 7 ends the segment
	always_comb begin
		if (is_flag) begin
			out_bit = cur_bit;
			seg_end = (bit_cnt_q == 3'd7);
		end else if (stuff_q) begin
			out_bit = 1'b0;
			seg_end = (bit_cnt_q == 3'd0);
		end else begin
			out_bit = cur_bit;
			seg_end = (bit_cnt_q == 3'd7) && !need_stuff;
		end
	end

	assign item_done = seg_end &&
		((phase_q == PH_CLOSE) || ((phase_q == PH_DATA) && !job_q.last));

	// segment sequencing
	always_comb begin
		case (phase_q)
			PH_OPEN:   phase_nx = PH_DATA;
			PH_DATA:   phase_nx = job_q.last ? PH_FCS_LO : PH_IDLE;
			PH_FCS_LO: phase_nx = PH_FCS_HI;
			PH_FCS_HI: phase_nx = PH_CLOSE;
			PH_CLOSE:  phase_nx = PH_IDLE;
			default:   phase_nx = PH_IDLE;
		endcase
	end

	// take the next job while idle or in the cycle that emits the current job's last bit
	assign load  = !q_empty && ((phase_q == PH_IDLE) || (emit && item_done));
	assign q_pop = load;

	// job payload
	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= q_data;
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (emit) begin
			line_bit_q <= out_bit;
			run_end_q  <= item_done;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			ones_q    <= '0;
			stuff_q   <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end

			if (emit) begin
				if (is_flag || !stuff_q) begin
					bit_cnt_q <= bit_cnt_q + 3'd1;
				end
				if (is_flag) begin
					ones_q <= (phase_q == PH_CLOSE && seg_end) ? 3'd0 : ones_q;
				end else if (stuff_q) begin
					ones_q <= 3'd0;
				end else begin
					ones_q <= need_stuff ? 3'd0 : ones_inc;
				end
				stuff_q <= need_stuff;
				if (seg_end) begin
					phase_q <= phase_nx;
				end
			end

			if (load) begin
				phase_q   <= q_data.open ? PH_OPEN : PH_DATA;
				bit_cnt_q <= '0;
			end
		end
	end

endmodule

FILE: sv/hdlc_bit_stuffing_framer_unit.sv
// ----------------------------------------------------------------------------
// hdlc_bit_stuffing_framer_unit
// HDLC framer: flags, LSB-first bytes with zero stuffing, CRC-16/X-25 FCS.
// ----------------------------------------------------------------------------
//  channel | handshake        | beat
//  --------+------------------+------------------------------
//  input   | push / full      | data_byte[7:0], frame_end
//  output  | pop / empty      | line_bit, run_end
//
//  One line bit leaves per cycle when pop is held high; a byte is 8 bits
//  plus up to two stuffed zeros; a flag opens each frame, FCS and flag end it.
//  The serializer's one-bit-per-cycle output register sets the rate.
//  Bytes are taken every cycle until the 4-entry job queue fills.
//  Reset (arst_n low) empties the queue and output and closes any frame.
//  A stall on pop holds the output beat; the front keeps accepting meanwhile.
// ----------------------------------------------------------------------------
module hdlc_bit_stuffing_framer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	output logic       line_bit,
	output logic       run_end,
	output logic       empty,
	input  logic       pop
);
	import hbsf_pkg::*;

	job_t front_job;
	job_t q_job;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic accept;

	assign full   = q_full;
	assign accept = push && !q_full;

	// byte classification and CRC
	hbsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.job       (front_job)
	);

	// decoupling queue
	hbsf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_job),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_job),
		.empty  (q_empty)
	);

	// bit serializer
	hbsf_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_data   (q_job),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.line_bit (line_bit),
		.run_end  (run_end),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

FILE: sv/hbsf_checker.sv
// ----------------------------------------------------------------------------
// hbsf_checker
// Port-level checks on the framer: reset, output hold and item accounting.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hbsf_checker (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic line_bit,
	input logic run_end,
	input logic empty,
	input logic pop
);
	import hbsf_pkg::*;

	logic [2:0] pend_q;
	logic       in_beat;
	logic       last_beat;

	assign in_beat   = push && !full;
	assign last_beat = pop && !empty && run_end;

	// bytes accepted whose last bit has not been taken yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_beat && !last_beat) begin
			pend_q <= pend_q + 3'd1;
		end else if (last_beat && !in_beat) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	`ASSERT_CLK_ALWAYS(a_reset_empty, clk, !arst_n |-> empty)
	`ASSERT_CLK(a_hold_on_stall, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(line_bit) && $stable(run_end)))
	`ASSERT_CLK(a_no_spurious_out, clk, arst_n, !empty |-> (pend_q != 3'd0))
	`ASSERT_CLK(a_pending_bound, clk, arst_n, pend_q <= 3'(QDEPTH + 2))
	`ASSERT_CLK(a_not_full_when_idle, clk, arst_n, (pend_q == 3'd0) |-> !full)

endmodule

bind hdlc_bit_stuffing_framer_unit hbsf_checker u_hbsf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.line_bit (line_bit),
	.run_end  (run_end),
	.empty    (empty),
	.pop      (pop)
);
